>>> design/addressed_serial_frame_receiver_core_macros.svh
// Assertion helpers for the checker file.
`ifndef ADDRESSED_SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH
`define ADDRESSED_SERIAL_FRAME_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/asfr_pkg.sv
package asfr_pkg;

    localparam logic [7:0] START_BYTE         = 8'h3A;
    localparam logic [7:0] NODE_ADDRESS_RESET = 8'd5;
    localparam int         HEADER_LEN         = 4;

    // Header byte positions
    localparam logic [1:0] HDR_ADDR  = 2'd0;
    localparam logic [1:0] HDR_FUNC  = 2'd1;
    localparam logic [1:0] HDR_SUBF  = 2'd2;
    localparam logic [1:0] HDR_COUNT = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } phase_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic [7:0] function_code;
        logic [7:0] subfunction_code;
        logic [7:0] data_count;
    } result_t;

endpackage

>>> design/asfr_rx_if.sv
interface asfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> design/asfr_res_if.sv
interface asfr_res_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic [7:0] function_code;
    logic [7:0] subfunction_code;
    logic [7:0] data_count;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_done, output function_code, output subfunction_code,
        output data_count, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_done, input function_code, input subfunction_code,
        input data_count, output ready
    );
endinterface

>>> design/asfr_parser.sv
module asfr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       node_address,
    output asfr_pkg::result_t result
);
    import asfr_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] header_reg [HEADER_LEN];
    logic       hdr_we;
    logic [7:0] addr_now;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        hdr_we     = 1'b0;
        addr_now   = header_reg[HDR_ADDR];
        result     = '0;

        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                if (count_reg < header_reg[HDR_COUNT])
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = count_reg;
                    count_next           = count_reg + 8'd1;
                end
                else
                begin
                    result.frame_done = 1'b1;
                    phase_next        = PH_IDLE;
                end
                result.function_code    = header_reg[HDR_FUNC];
                result.subfunction_code = header_reg[HDR_SUBF];
                result.data_count       = header_reg[HDR_COUNT];
            end
            PH_IDLE:
            begin
                if (rx_byte == START_BYTE)
                begin
                    phase_next = PH_HEADER;
                    count_next = '0;
                end
            end
            PH_HEADER:
            begin
                // start bytes inside the header are dropped
                if (rx_byte != START_BYTE)
                begin
                    hdr_we     = 1'b1;
                    count_next = count_reg + 8'd1;
                    if (count_reg[1:0] == HDR_COUNT)
                    begin
                        // last header byte: the address was stored earlier
                        count_next = '0;
                        phase_next = (addr_now == node_address) ? PH_PAYLOAD : PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hdr_we)
        begin
            header_reg[count_reg[1:0]] <= rx_byte;
        end
    end

endmodule

>>> design/addressed_serial_frame_receiver_core.sv
// A result word appears on res_ch in the cycle after its rx word is accepted.
// Throughput: one rx word per cycle; the result register lets rx proceed while
// a result is taken in the same cycle, and rx stalls only while res_ch stalls.
// Reset: rst_n clears the frame state to idle, node_address to 5 and the result
// register to empty; stored header bytes are not cleared.
module addressed_serial_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    asfr_rx_if.sink     rx_ch,
    asfr_res_if.source  res_ch
);
    import asfr_pkg::*;

    logic [7:0] node_address_reg;
    logic       res_valid_reg;
    result_t    res_data_reg;
    result_t    result;
    logic       rx_take;

    assign rx_ch.ready = !res_valid_reg || res_ch.ready;
    assign rx_take     = rx_ch.valid && rx_ch.ready;

    asfr_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (rx_take),
        .rx_byte      (rx_ch.rx_byte),
        .node_address (node_address_reg),
        .result       (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= NODE_ADDRESS_RESET;
        end
        else if (cfg_we)
        begin
            node_address_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rx_take)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
        begin
            res_data_reg <= result;
        end
    end

    assign res_ch.valid            = res_valid_reg;
    assign res_ch.payload_valid    = res_data_reg.payload_valid;
    assign res_ch.payload_byte     = res_data_reg.payload_byte;
    assign res_ch.payload_index    = res_data_reg.payload_index;
    assign res_ch.frame_done       = res_data_reg.frame_done;
    assign res_ch.function_code    = res_data_reg.function_code;
    assign res_ch.subfunction_code = res_data_reg.subfunction_code;
    assign res_ch.data_count       = res_data_reg.data_count;

endmodule

>>> design/asfr_checker.sv
`include "addressed_serial_frame_receiver_core_macros.svh"

module asfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       payload_valid,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic       frame_done,
    input logic [7:0] function_code,
    input logic [7:0] subfunction_code,
    input logic [7:0] data_count
);

    `ASFR_ASSERT_NOW(a_not_both, res_valid, !(payload_valid && frame_done), "payload and done together")

    `ASFR_ASSERT_NOW(a_idle_zero, res_valid && !payload_valid && !frame_done, function_code == 8'd0 && subfunction_code == 8'd0 && data_count == 8'd0, "header fields set on an empty word")

    `ASFR_ASSERT_NOW(a_nopay_zero, res_valid && !payload_valid, payload_byte == 8'd0 && payload_index == 8'd0, "payload fields set without payload")

    `ASFR_ASSERT_NOW(a_rx_open, !res_valid || res_ready, rx_ready, "rx stalled with room in result register")

    `ASFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(payload_byte) && $stable(frame_done), "stalled result word changed")

endmodule

bind addressed_serial_frame_receiver_core asfr_checker u_asfr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_ready         (rx_ch.ready),
    .res_valid        (res_ch.valid),
    .res_ready        (res_ch.ready),
    .payload_valid    (res_ch.payload_valid),
    .payload_byte     (res_ch.payload_byte),
    .payload_index    (res_ch.payload_index),
    .frame_done       (res_ch.frame_done),
    .function_code    (res_ch.function_code),
    .subfunction_code (res_ch.subfunction_code),
    .data_count       (res_ch.data_count)
);
